// ----- rtl/til_pkg.sv -----
// Shared constants, codes and types of the timed interval lookup block.
// No dependencies; imported by the core and the search sequencer.
package til_pkg;

  localparam int MAX_LINES = 256;
  localparam int TIME_BITS = 32;

  localparam int AW    = $clog2(MAX_LINES);
  localparam int CW    = $clog2(MAX_LINES + 1);
  localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS + 1 : 33;
  localparam int ENT_W = TIME_BITS + 33;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } til_mode_e;

  typedef enum logic {
    REG_LINE_COUNT     = 1'b0,
    REG_TIMING_PRESENT = 1'b1
  } til_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_ENDCHK,
    ST_HOLD
  } til_state_e;

  typedef struct packed {
    logic          valid;
    logic          found;
    logic [AW-1:0] index;
  } til_res_t;

endpackage

// ----- rtl/timed_interval_lookup_core.sv -----
// Timed interval lookup: interval table in RAM, binary search per query.
// A load item writes its entry without leaving idle and gives no result.
// A query holds the input until its result issues: one RAM probe per cycle through the
// shared comparator, then one end check.
// Misses caught at entry skip the search; a result waits while the output register is full.
// Reset clears control and config; table is not cleared.
module timed_interval_lookup_core import til_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [7:0]         slot_i,
  input  logic [31:0]        start_ms_i,
  input  logic signed [32:0] end_ms_i,
  input  logic signed [32:0] position_ms_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               found_o,
  output logic [7:0]         line_index_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [8:0]         cfg_wdata_i
);

  logic [8:0]        line_count_q;
  logic              timing_q;
  logic              out_valid_q;
  logic              found_q;
  logic [AW-1:0]     index_q;

  logic              idle;
  logic              in_acc;
  logic              load_we;
  logic              query_go;
  logic              out_free;
  logic [CW-1:0]     n_eff;
  logic [AW-1:0]     raddr;
  logic [ENT_W-1:0]  rdata;
  til_res_t          res;

  assign in_ready_o = idle;
  assign in_acc     = in_valid_i && in_ready_o;
  assign load_we    = in_acc && (mode_i == MODE_LOAD) && (32'(slot_i) < MAX_LINES);
  assign query_go   = in_acc && (mode_i == MODE_QUERY);
  assign out_free   = !out_valid_q || out_ready_i;
  assign n_eff      = (32'(line_count_q) > MAX_LINES) ? CW'(MAX_LINES) : CW'(line_count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_count_q <= '0;
      timing_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LINE_COUNT:     line_count_q <= cfg_wdata_i;
        REG_TIMING_PRESENT: timing_q     <= cfg_wdata_i[0];
        default:            ;
      endcase
    end
  end

  til_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_LINES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (AW'(slot_i)),
    .wdata_i ({end_ms_i, TIME_BITS'(start_ms_i)}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  til_search u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (query_go),
    .pos_i       (position_ms_i),
    .n_i         (n_eff),
    .timing_i    (timing_q),
    .ent_start_i (rdata[TIME_BITS-1:0]),
    .ent_end_i   (rdata[ENT_W-1:TIME_BITS]),
    .out_free_i  (out_free),
    .idle_o      (idle),
    .raddr_o     (raddr),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      found_q <= res.found;
      index_q <= res.index;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = found_q;
  assign line_index_o = 8'(index_q);

  a_res_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> out_free)
    else $error("result issued while output register full");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.valid && !res.found) |-> (res.index == '0))
    else $error("miss with nonzero index");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_go |=> !in_ready_o)
    else $error("ready right after query item");

  a_no_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle |-> !res.valid)
    else $error("result from idle sequencer");

endmodule

// ----- rtl/til_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module til_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/til_search.sv -----
// Upper-bound binary search sequencer with one shared magnitude comparator,
// used for the start probes and the final end check. Depends on til_pkg.
module til_search import til_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [32:0]   pos_i,
  input  logic [CW-1:0]        n_i,
  input  logic                 timing_i,
  input  logic [TIME_BITS-1:0] ent_start_i,
  input  logic signed [32:0]   ent_end_i,
  input  logic                 out_free_i,
  output logic                 idle_o,
  output logic [AW-1:0]        raddr_o,
  output til_res_t             res_o
);

  til_state_e state_q, state_d;
  logic [CMP_W-1:0] pos_q, pos_d;
  logic [CW-1:0]    lo_q, lo_d, cnt_q, cnt_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic             hfound_q, hfound_d;
  logic [AW-1:0]    hidx_q, hidx_d;

  logic [CMP_W-1:0] op_b;
  logic             ge;
  logic [CW-1:0]    half, lo_n, cnt_n;
  til_res_t         res_c;
  logic             emit;

  // shared comparator
  assign op_b = (state_q == ST_ENDCHK) ? CMP_W'(ent_end_i[31:0]) : CMP_W'(ent_start_i);
  assign ge   = (pos_q >= op_b);

  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    lo_d     = lo_q;
    cnt_d    = cnt_q;
    addr_d   = addr_q;
    hfound_d = hfound_q;
    hidx_d   = hidx_q;
    half     = cnt_q >> 1;
    lo_n     = lo_q;
    cnt_n    = half;
    res_c    = '0;
    emit     = 1'b0;
    res_o    = '0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          pos_d = CMP_W'(pos_i[31:0]);
          if (!timing_i || n_i == '0 || pos_i[32]) begin
            hfound_d = 1'b0;
            hidx_d   = '0;
            state_d  = ST_HOLD;
          end else begin
            lo_d    = '0;
            cnt_d   = n_i;
            addr_d  = AW'(n_i >> 1);
            state_d = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (ge) begin
          lo_n  = CW'(addr_q) + CW'(1);
          cnt_n = cnt_q - half - CW'(1);
        end
        lo_d  = lo_n;
        cnt_d = cnt_n;
        if (cnt_n != '0) begin
          addr_d = AW'(lo_n + (cnt_n >> 1));
        end else if (lo_n == '0) begin
          emit = 1'b1;
        end else begin
          addr_d  = AW'(lo_n - CW'(1));
          state_d = ST_ENDCHK;
        end
      end
      ST_ENDCHK: begin
        emit = 1'b1;
        if (ent_end_i[32] || !ge) begin
          res_c.found = 1'b1;
          res_c.index = addr_q;
        end
      end
      ST_HOLD: begin
        res_o.valid = out_free_i;
        res_o.found = hfound_q;
        res_o.index = hidx_q;
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (emit) begin
      if (out_free_i) begin
        res_o       = res_c;
        res_o.valid = 1'b1;
        state_d     = ST_IDLE;
      end else begin
        hfound_d = res_c.found;
        hidx_d   = res_c.index;
        state_d  = ST_HOLD;
      end
    end
  end

  assign idle_o  = (state_q == ST_IDLE);
  assign raddr_o = addr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    lo_q     <= lo_d;
    cnt_q    <= cnt_d;
    addr_q   <= addr_d;
    hfound_q <= hfound_d;
    hidx_q   <= hidx_d;
  end

endmodule
